// ===== rtl/core/rlmf_pkg.sv =====
// Shared types and constants for the RGB Laplacian mirror filter.
// No dependencies; imported by every module of the filter except rlmf_ram.
package rlmf_pkg;

    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 16;
    localparam int WIDTH_REG_W  = 12;
    localparam int HEIGHT_REG_W = 16;
    localparam int GAIN_W       = 8;
    localparam int CHAN_W       = 8;
    localparam int ROW_W        = HEIGHT_REG_W + 1;
    localparam int SUM_W        = CHAN_W + 3;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_GAIN         = 2'd2;

    localparam logic [WIDTH_REG_W-1:0]  IMAGE_WIDTH_RESET  = 12'd512;
    localparam logic [HEIGHT_REG_W-1:0] IMAGE_HEIGHT_RESET = 16'd512;
    localparam logic [GAIN_W-1:0]       GAIN_RESET         = 8'd6;

    localparam logic CMD_PUSH  = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } pixel_t;

    // low bytes of the absolute Laplacian sums, before gain
    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              frame_end;
    } result_t;

endpackage

// ===== rtl/core/rlmf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for both line stores.
module rlmf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= store_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/rlmf_front.sv =====
// Front part: accepts items, classifies them, keeps the raster counters, line stores
// and the filter window, and pushes absolute Laplacian sums. Depends on rlmf_pkg, rlmf_ram.
module rlmf_front #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             cmd,
    input  rlmf_pkg::pixel_t                 pixel,
    input  logic [rlmf_pkg::WIDTH_REG_W-1:0]  image_width,
    input  logic [rlmf_pkg::HEIGHT_REG_W-1:0] image_height,
    input  logic                             q_space,
    output logic                             push,
    output rlmf_pkg::result_t                push_data
);

    import rlmf_pkg::*;

    localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CW = (XW + 1 > WIDTH_REG_W) ? XW + 1 : WIDTH_REG_W;

    typedef struct packed {
        logic result;
        logic frame_end;
        logic lf_new;
        logic rt_new;
        logic top_mirror;
        logic bot_mirror;
        logic fwd;
    } step_ctl_t;

    function automatic logic [CHAN_W-1:0] lap_abs_low(
        input logic [CHAN_W-1:0] ctr,
        input logic [CHAN_W-1:0] up,
        input logic [CHAN_W-1:0] dn,
        input logic [CHAN_W-1:0] lf,
        input logic [CHAN_W-1:0] rt
    );
        logic [SUM_W-1:0] s;
        logic [SUM_W-1:0] mag;
        s = SUM_W'(up) + SUM_W'(dn) + SUM_W'(lf) + SUM_W'(rt) - {1'b0, ctr, 2'b00};
        mag = s[SUM_W-1] ? (~s + 1'b1) : s;
        return mag[CHAN_W-1:0];
    endfunction

    logic [XW-1:0]    col_reg;
    logic [XW-1:0]    col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    logic [CW-1:0]    w_eff;
    logic [CW-1:0]    col_ext;
    logic [CW-1:0]    col_inc;
    logic [ROW_W-1:0] h_eff;
    logic [ROW_W-1:0] h_inc;
    logic             col_zero;
    logic             drop;
    logic             ignore;
    logic             proc;
    logic             accept;
    logic             advance;
    step_ctl_t        ctl;

    logic             pipe_valid_reg;
    logic             pipe_valid_next;
    step_ctl_t        pipe_ctl_reg;
    logic [XW-1:0]    pipe_idx_reg;
    pixel_t           pipe_pix_reg;
    pixel_t           fwd_upper_reg;
    pixel_t           fwd_middle_reg;

    pixel_t           win_c1r1_reg;
    pixel_t           win_c2r0_reg;
    pixel_t           win_c2r1_reg;
    pixel_t           win_c2r2_reg;

    pixel_t           upper_q;
    pixel_t           middle_q;
    pixel_t           upper_px;
    pixel_t           middle_px;
    pixel_t           tap_up;
    pixel_t           tap_dn;
    pixel_t           tap_lf;
    pixel_t           tap_rt;
    pixel_t           tap_ctr;

    always_comb
    begin
        if (image_width < WIDTH_REG_W'(2))
        begin
            w_eff = CW'(2);
        end
        else if (CW'(image_width) > CW'(MAX_WIDTH))
        begin
            w_eff = CW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = CW'(image_width);
        end
        h_eff    = (image_height < HEIGHT_REG_W'(2)) ? ROW_W'(2) : ROW_W'(image_height);
        h_inc    = h_eff + 1'b1;
        col_ext  = CW'(col_reg);
        col_inc  = col_ext + 1'b1;
        col_zero = (col_reg == '0);
        drop     = (row_reg > h_inc) || ((row_reg == h_inc) && !col_zero);
        ignore   = (cmd == CMD_PUSH) ? (row_reg >= h_eff) : (row_reg < h_eff);
        proc     = !drop && !ignore;
    end

    always_comb
    begin
        ctl     = '0;
        ctl.fwd = pipe_valid_reg && (pipe_idx_reg == col_reg);
        if (col_zero)
        begin
            ctl.result     = (row_reg >= ROW_W'(2)) && (row_reg <= h_inc);
            ctl.frame_end  = ctl.result && (row_reg == h_inc);
            ctl.top_mirror = (row_reg == ROW_W'(2));
            ctl.bot_mirror = (row_reg >= h_inc);
        end
        else
        begin
            ctl.result     = (row_reg != '0) && (row_reg <= h_eff);
            ctl.frame_end  = ctl.result && (row_reg == h_eff) && (col_ext == w_eff);
            ctl.top_mirror = (row_reg == ROW_W'(1));
            ctl.bot_mirror = (row_reg >= h_eff);
            ctl.lf_new     = (col_reg == XW'(1));
            ctl.rt_new     = (col_ext < w_eff);
        end
    end

    assign advance  = !pipe_ctl_reg.result || q_space;
    assign in_ready = !pipe_valid_reg || advance;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            priority if (drop)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (proc)
            begin
                priority if (ctl.frame_end)
                begin
                    col_next = '0;
                    row_next = '0;
                end
                else if (col_inc >= w_eff)
                begin
                    col_next = '0;
                    row_next = row_reg + 1'b1;
                end
                else
                begin
                    col_next = col_inc[XW-1:0];
                end
            end
            else
            begin
                col_next = col_reg;
                row_next = row_reg;
            end
        end
    end

    always_comb
    begin
        pipe_valid_next = pipe_valid_reg;
        if (accept)
        begin
            pipe_valid_next = proc;
        end
        else if (advance)
        begin
            pipe_valid_next = 1'b0;
        end
    end

    assign upper_px  = pipe_ctl_reg.fwd ? fwd_upper_reg : upper_q;
    assign middle_px = pipe_ctl_reg.fwd ? fwd_middle_reg : middle_q;
    assign tap_ctr   = win_c2r1_reg;
    assign tap_up    = pipe_ctl_reg.top_mirror ? win_c2r2_reg : win_c2r0_reg;
    assign tap_dn    = pipe_ctl_reg.bot_mirror ? win_c2r0_reg : win_c2r2_reg;
    assign tap_lf    = pipe_ctl_reg.lf_new ? middle_px : win_c1r1_reg;
    assign tap_rt    = pipe_ctl_reg.rt_new ? middle_px : win_c1r1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg        <= '0;
            row_reg        <= '0;
            pipe_valid_reg <= 1'b0;
            win_c1r1_reg   <= '0;
            win_c2r0_reg   <= '0;
            win_c2r1_reg   <= '0;
            win_c2r2_reg   <= '0;
        end
        else
        begin
            col_reg        <= col_next;
            row_reg        <= row_next;
            pipe_valid_reg <= pipe_valid_next;
            if (pipe_valid_reg && advance)
            begin
                win_c1r1_reg <= win_c2r1_reg;
                win_c2r0_reg <= upper_px;
                win_c2r1_reg <= middle_px;
                win_c2r2_reg <= pipe_pix_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && proc)
        begin
            pipe_ctl_reg   <= ctl;
            pipe_idx_reg   <= col_reg;
            pipe_pix_reg   <= (cmd == CMD_DRAIN) ? '0 : pixel;
            fwd_upper_reg  <= middle_px;
            fwd_middle_reg <= pipe_pix_reg;
        end
    end

    rlmf_ram #(
        .WIDTH ($bits(pixel_t)),
        .DEPTH (MAX_WIDTH)
    ) u_upper_store (
        .clk   (clk),
        .we    (pipe_valid_reg && advance),
        .waddr (pipe_idx_reg),
        .wdata (middle_px),
        .re    (accept && proc),
        .raddr (col_reg),
        .rdata (upper_q)
    );

    rlmf_ram #(
        .WIDTH ($bits(pixel_t)),
        .DEPTH (MAX_WIDTH)
    ) u_middle_store (
        .clk   (clk),
        .we    (pipe_valid_reg && advance),
        .waddr (pipe_idx_reg),
        .wdata (pipe_pix_reg),
        .re    (accept && proc),
        .raddr (col_reg),
        .rdata (middle_q)
    );

    assign push = pipe_valid_reg && pipe_ctl_reg.result && q_space;

    always_comb
    begin
        push_data.blue      = lap_abs_low(tap_ctr.blue, tap_up.blue, tap_dn.blue,
                                          tap_lf.blue, tap_rt.blue);
        push_data.green     = lap_abs_low(tap_ctr.green, tap_up.green, tap_dn.green,
                                          tap_lf.green, tap_rt.green);
        push_data.red       = lap_abs_low(tap_ctr.red, tap_up.red, tap_dn.red,
                                          tap_lf.red, tap_rt.red);
        push_data.frame_end = pipe_ctl_reg.frame_end;
    end

endmodule

// ===== rtl/core/rlmf_queue.sv =====
// Short queue between front and back parts of the filter.
// Depends on rlmf_pkg for the entry type and depth.
module rlmf_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  rlmf_pkg::result_t push_data,
    output logic              space,
    input  logic              pop,
    output logic              head_valid,
    output rlmf_pkg::result_t head_data
);

    import rlmf_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    result_t       entry_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [NW-1:0] count_reg;
    logic [NW-1:0] count_next;

    assign space      = (count_reg < NW'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/core/rlmf_back.sv =====
// Back part: applies the gain to each channel and holds the output register.
// Depends on rlmf_pkg.
module rlmf_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [rlmf_pkg::GAIN_W-1:0] gain,
    input  logic                        head_valid,
    input  rlmf_pkg::result_t           head_data,
    output logic                        pop,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [rlmf_pkg::CHAN_W-1:0] out_blue,
    output logic [rlmf_pkg::CHAN_W-1:0] out_green,
    output logic [rlmf_pkg::CHAN_W-1:0] out_red,
    output logic                        frame_end
);

    import rlmf_pkg::*;

    localparam int PRODUCT_W = CHAN_W + GAIN_W;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [CHAN_W-1:0]    blue_reg;
    logic [CHAN_W-1:0]    green_reg;
    logic [CHAN_W-1:0]    red_reg;
    logic                 frame_end_reg;
    logic [PRODUCT_W-1:0] prod_blue;
    logic [PRODUCT_W-1:0] prod_green;
    logic [PRODUCT_W-1:0] prod_red;

    assign pop        = head_valid && (!out_valid_reg || out_ready);
    assign prod_blue  = PRODUCT_W'(head_data.blue) * PRODUCT_W'(gain);
    assign prod_green = PRODUCT_W'(head_data.green) * PRODUCT_W'(gain);
    assign prod_red   = PRODUCT_W'(head_data.red) * PRODUCT_W'(gain);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            blue_reg      <= prod_blue[CHAN_W-1:0];
            green_reg     <= prod_green[CHAN_W-1:0];
            red_reg       <= prod_red[CHAN_W-1:0];
            frame_end_reg <= head_data.frame_end;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_blue  = blue_reg;
    assign out_green = green_reg;
    assign out_red   = red_reg;
    assign frame_end = frame_end_reg;

endmodule

// ===== rtl/core/rgb_laplacian_mirror_filter_core.sv =====
// Top level of the streaming RGB 3x3 Laplacian filter with reflect-101 borders.
// Holds the configuration registers; depends on rlmf_pkg, rlmf_front, rlmf_queue, rlmf_back.
//
//   channel | handshake             | payload
//   --------+-----------------------+------------------------------------------
//   config  | cfg_write             | cfg_index, cfg_data
//   input   | in_valid / in_ready   | cmd, in_blue, in_green, in_red
//   output  | out_valid / out_ready | out_blue, out_green, out_red, frame_end
//
// One item per clock while the output does not back up; the result of a transfer passes
// the line-store read, the sum stage and the gain stage before the output register.
// Results trail the pixel stream by one row plus one pixel; image_width+1 drain
// transfers flush a frame. Reset clears counters, window and queue; line stores
// need no clearing pass. A stalled output backs up through the two-entry queue.
module rgb_laplacian_mirror_filter_core #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [rlmf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rlmf_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             cmd,
    input  logic [rlmf_pkg::CHAN_W-1:0]      in_blue,
    input  logic [rlmf_pkg::CHAN_W-1:0]      in_green,
    input  logic [rlmf_pkg::CHAN_W-1:0]      in_red,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [rlmf_pkg::CHAN_W-1:0]      out_blue,
    output logic [rlmf_pkg::CHAN_W-1:0]      out_green,
    output logic [rlmf_pkg::CHAN_W-1:0]      out_red,
    output logic                             frame_end
);

    import rlmf_pkg::*;

    logic [WIDTH_REG_W-1:0]  image_width_reg;
    logic [HEIGHT_REG_W-1:0] image_height_reg;
    logic [GAIN_W-1:0]       gain_reg;
    pixel_t                  pixel;
    logic                    push;
    result_t                 push_data;
    logic                    q_space;
    logic                    pop;
    logic                    head_valid;
    result_t                 head_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= IMAGE_WIDTH_RESET;
            image_height_reg <= IMAGE_HEIGHT_RESET;
            gain_reg         <= GAIN_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[WIDTH_REG_W-1:0];
                CFG_IMAGE_HEIGHT: image_height_reg <= cfg_data[HEIGHT_REG_W-1:0];
                CFG_GAIN:         gain_reg         <= cfg_data[GAIN_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        pixel.blue  = in_blue;
        pixel.green = in_green;
        pixel.red   = in_red;
    end

    rlmf_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .pixel        (pixel),
        .image_width  (image_width_reg),
        .image_height (image_height_reg),
        .q_space      (q_space),
        .push         (push),
        .push_data    (push_data)
    );

    rlmf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .space      (q_space),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    rlmf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .gain       (gain_reg),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_blue   (out_blue),
        .out_green  (out_green),
        .out_red    (out_red),
        .frame_end  (frame_end)
    );

endmodule

// ===== test/tb_rgb_laplacian_mirror_filter_core.sv =====
// Testbench for rgb_laplacian_mirror_filter_core: raster frames in, filtered pixels out,
// each checked against an in-bench Laplacian predictor with reflect-101 borders.
// Depends on rlmf_pkg and the filter core RTL only.
module tb_rgb_laplacian_mirror_filter_core;

    import rlmf_pkg::*;

    localparam int LINE_MAX = 2048;

    typedef enum {PAT_RANDOM, PAT_CHECKER, PAT_SATURATE} pattern_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   in_valid  = 1'b0;
    logic                   in_ready;
    logic                   cmd       = CMD_PUSH;
    logic [CHAN_W-1:0]      in_blue   = '0;
    logic [CHAN_W-1:0]      in_green  = '0;
    logic [CHAN_W-1:0]      in_red    = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [CHAN_W-1:0]      out_blue;
    logic [CHAN_W-1:0]      out_green;
    logic [CHAN_W-1:0]      out_red;
    logic                   frame_end;

    rgb_laplacian_mirror_filter_core #(.MAX_WIDTH(LINE_MAX)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .in_blue   (in_blue),
        .in_green  (in_green),
        .in_red    (in_red),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_blue  (out_blue),
        .out_green (out_green),
        .out_red   (out_red),
        .frame_end (frame_end)
    );

    always #1 clk = ~clk;

    // predictor state
    pixel_t                  upper_line [LINE_MAX];
    pixel_t                  middle_line [LINE_MAX];
    pixel_t                  window_px [9];
    int unsigned             col_in = 0;
    int unsigned             row_in = 0;
    logic [WIDTH_REG_W-1:0]  cfg_width  = IMAGE_WIDTH_RESET;
    logic [HEIGHT_REG_W-1:0] cfg_height = IMAGE_HEIGHT_RESET;
    logic [GAIN_W-1:0]       cfg_gain   = GAIN_RESET;

    result_t pending_filtered [$];
    int      mismatch_count = 0;
    int      in_gap_pct     = 0;
    int      hold_pct       = 0;
    int      hold_left      = 0;

    initial
    begin
        for (int i = 0; i < LINE_MAX; i++)
        begin
            upper_line[i]  = '0;
            middle_line[i] = '0;
        end
        for (int i = 0; i < 9; i++)
        begin
            window_px[i] = '0;
        end
    end

    function automatic int unsigned active_width();
        if (cfg_width < 2)
            return 2;
        if (cfg_width > LINE_MAX)
            return LINE_MAX;
        return cfg_width;
    endfunction

    function automatic int unsigned active_height();
        return (cfg_height < 2) ? 2 : cfg_height;
    endfunction

    function automatic logic [CHAN_W-1:0] lap_channel(input logic [CHAN_W-1:0] c, u, d, l, r);
        int          s;
        int unsigned a;
        s = int'(u) + int'(d) + int'(l) + int'(r) - 4 * int'(c);
        a = (s < 0) ? -s : s;
        return CHAN_W'(a * cfg_gain);
    endfunction

    function automatic bit filter_step(input logic c, input pixel_t pin, output result_t res);
        int unsigned w, h, x, r, idx, cr, cc, lcol, ccol, rcol, trow, brow;
        pixel_t      pix, u, m, ctr, up, dn, lf, rt;
        pixel_t      prev [9];
        pixel_t      src [9];
        bit          ok;
        w   = active_width();
        h   = active_height();
        x   = col_in;
        r   = row_in;
        pix = pin;
        res = '0;
        if (r > h + 1 || (r == h + 1 && x != 0))
        begin
            col_in = 0;
            row_in = 0;
            return 1'b0;
        end
        if (c == CMD_PUSH && r >= h)
            return 1'b0;
        if (c == CMD_DRAIN && r < h)
            return 1'b0;
        if (c == CMD_DRAIN)
            pix = '0;

        prev = window_px;
        idx  = (x < LINE_MAX) ? x : LINE_MAX - 1;
        u    = upper_line[idx];
        m    = middle_line[idx];
        upper_line[idx]  = m;
        middle_line[idx] = pix;
        for (int i = 0; i < 6; i++)
        begin
            window_px[i] = window_px[i + 3];
        end
        window_px[6] = u;
        window_px[7] = m;
        window_px[8] = pix;

        if (x >= 1)
        begin
            ok   = (r >= 1);
            cr   = r - 1;
            cc   = x - 1;
            src  = window_px;
            ccol = 1;
            lcol = (cc == 0) ? 2 : 0;
            rcol = (cc + 1 >= w) ? 0 : 2;
        end
        else
        begin
            ok   = (r >= 2);
            cr   = r - 2;
            cc   = w - 1;
            src  = prev;
            ccol = 2;
            lcol = 1;
            rcol = 1;
        end

        if (x + 1 >= w)
        begin
            col_in = 0;
            row_in = r + 1;
        end
        else
        begin
            col_in = x + 1;
        end

        if (!ok || cr > h - 1)
            return 1'b0;

        trow = (cr == 0) ? 2 : 0;
        brow = (cr + 1 >= h) ? 0 : 2;
        ctr  = src[ccol * 3 + 1];
        up   = src[ccol * 3 + trow];
        dn   = src[ccol * 3 + brow];
        lf   = src[lcol * 3 + 1];
        rt   = src[rcol * 3 + 1];

        res.red       = lap_channel(ctr.red, up.red, dn.red, lf.red, rt.red);
        res.green     = lap_channel(ctr.green, up.green, dn.green, lf.green, rt.green);
        res.blue      = lap_channel(ctr.blue, up.blue, dn.blue, lf.blue, rt.blue);
        res.frame_end = (cr == h - 1 && cc == w - 1);
        if (res.frame_end)
        begin
            col_in = 0;
            row_in = 0;
        end
        return 1'b1;
    endfunction

    function automatic pixel_t rand_pixel();
        return pixel_t'(24'($urandom));
    endfunction

    // output side: random stall bursts
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if ($urandom_range(1, 100) <= hold_pct)
        begin
            out_ready <= 1'b0;
            hold_left <= $urandom_range(0, 4);
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_filtered.size() == 0)
            begin
                if (mismatch_count < 10)
                    $display("unexpected pixel out: r=%0h g=%0h b=%0h fe=%0b",
                             out_red, out_green, out_blue, frame_end);
                mismatch_count++;
            end
            else
            begin
                want = pending_filtered.pop_front();
                if (out_red !== want.red || out_green !== want.green ||
                    out_blue !== want.blue || frame_end !== want.frame_end)
                begin
                    if (mismatch_count < 10)
                        $display(
                            "mismatch: exp r=%0h g=%0h b=%0h fe=%0b, got r=%0h g=%0h b=%0h fe=%0b",
                            want.red, want.green, want.blue, want.frame_end,
                            out_red, out_green, out_blue, frame_end);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic send_item(input logic c, input pixel_t p);
        result_t res;
        if (in_gap_pct != 0 && $urandom_range(1, 100) <= in_gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= c;
        in_red   <= p.red;
        in_green <= p.green;
        in_blue  <= p.blue;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (filter_step(c, p, res))
            pending_filtered.push_back(res);
    endtask

    // hold the input until every expected pixel is out, then let the pipe empty
    task automatic wait_results(input int extra);
        in_valid <= 1'b0;
        while (pending_filtered.size() != 0)
            @(negedge clk);
        @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic set_config(input int w_reg, input int h_reg, input int g);
        cfg_write <= 1'b1;
        cfg_index <= CFG_IMAGE_WIDTH;
        cfg_data  <= CFG_DATA_W'(w_reg);
        @(posedge clk);
        cfg_index <= CFG_IMAGE_HEIGHT;
        cfg_data  <= CFG_DATA_W'(h_reg);
        @(posedge clk);
        cfg_index <= CFG_GAIN;
        cfg_data  <= CFG_DATA_W'(g);
        @(posedge clk);
        cfg_write  <= 1'b0;
        cfg_width  = WIDTH_REG_W'(w_reg);
        cfg_height = HEIGHT_REG_W'(h_reg);
        cfg_gain   = GAIN_W'(g);
    endtask

    task automatic run_frame(input int w_reg, input int h_reg, input int g,
                             input pattern_t pat, input int noise_pct, input bit pause_mid);
        int unsigned w, h;
        pixel_t      p;
        set_config(w_reg, h_reg, g);
        w = active_width();
        h = active_height();
        for (int rr = 0; rr < h; rr++)
        begin
            for (int cc = 0; cc < w; cc++)
            begin
                if ($urandom_range(1, 100) <= noise_pct)
                    send_item(CMD_DRAIN, rand_pixel());
                if (pause_mid && rr == h / 2 && cc == 0)
                    wait_results(0);
                case (pat)
                    PAT_CHECKER:  p = ((rr + cc) % 2 != 0) ? '1 : '0;
                    PAT_SATURATE: p = {{CHAN_W{1'($urandom)}}, {CHAN_W{1'($urandom)}},
                                       {CHAN_W{1'($urandom)}}};
                    default:      p = rand_pixel();
                endcase
                send_item(CMD_PUSH, p);
            end
        end
        for (int d = 0; d <= w; d++)
        begin
            if ($urandom_range(1, 100) <= noise_pct)
                send_item(CMD_PUSH, rand_pixel());
            send_item(CMD_DRAIN, rand_pixel());
        end
        wait_results(8);
    endtask

    task automatic test_extreme_pixels();
        run_frame(2, 2, 8'hFF, PAT_CHECKER, 0, 1'b0);
    endtask

    task automatic test_clamped_sizes();
        run_frame(1, 0, 0, PAT_RANDOM, 0, 1'b0);
    endtask

    task automatic test_ignored_commands();
        in_gap_pct = 20;
        hold_pct   = 20;
        run_frame(2, 2, 7, PAT_SATURATE, 50, 1'b0);
    endtask

    task automatic test_dropped_frame();
        set_config(2, 16'hFFFF, 8'hFF);
        for (int i = 0; i < 8; i++)
            send_item(CMD_PUSH, rand_pixel());
        wait_results(8);
        // shrink the frame under the input position: next transfer drops it
        set_config(2, 1, 8'hFF);
        send_item(CMD_PUSH, rand_pixel());
        wait_results(8);
    endtask

    task automatic test_random_frames();
        int       w_reg, h_reg, noise;
        bit       calm;
        pattern_t pat;
        for (int frame_no = 0; frame_no < 18; frame_no++)
        begin
            calm       = (frame_no >= 15);
            in_gap_pct = calm ? 0 : $urandom_range(0, 3) * 10;
            hold_pct   = calm ? 0 : $urandom_range(0, 3) * 10;
            w_reg = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 9);
            h_reg = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 6);
            if (frame_no == 4)
            begin
                w_reg = 24;
                h_reg = 2;
            end
            pat   = ($urandom_range(0, 3) == 0) ? PAT_SATURATE : PAT_RANDOM;
            noise = (!calm && $urandom_range(0, 2) == 0) ? 10 : 0;
            run_frame(w_reg, h_reg, $urandom_range(0, 255), pat, noise,
                      !calm && $urandom_range(0, 5) == 0);
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extreme_pixels();
        test_clamped_sizes();
        test_ignored_commands();
        test_dropped_frame();
        test_random_frames();
        if (mismatch_count == 0 && pending_filtered.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== rgb_laplacian_mirror_filter_core.f =====
rtl/core/rlmf_pkg.sv
rtl/core/rlmf_ram.sv
rtl/core/rlmf_front.sv
rtl/core/rlmf_queue.sv
rtl/core/rlmf_back.sv
rtl/core/rgb_laplacian_mirror_filter_core.sv
test/tb_rgb_laplacian_mirror_filter_core.sv
